// File: design/scancode_to_char_fifo_unit_macros.svh
// assertion macros for the scancode to character ring unit
// used by the top level only, no other dependencies
`ifndef SCANCODE_TO_CHAR_FIFO_UNIT_MACROS_SVH
`define SCANCODE_TO_CHAR_FIFO_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define SCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication, checked out of reset
`define SCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define SCF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/scfifo_pkg.sv
// shared types, codes and the set-1 character map
// no dependencies
`timescale 1ns / 1ps

package scfifo_pkg;

  // word kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // navigation scancodes
  localparam logic [7:0] SC_HOME = 8'h47;
  localparam logic [7:0] SC_UP   = 8'h48;
  localparam logic [7:0] SC_PGUP = 8'h49;
  localparam logic [7:0] SC_END  = 8'h4F;
  localparam logic [7:0] SC_DOWN = 8'h50;
  localparam logic [7:0] SC_PGDN = 8'h51;

  localparam int         SCREEN_ROWS    = 25;
  localparam logic [7:0] PAGE_LINES_RST = 8'd20;

  // ring control from the decode side
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [6:0] push_char;
  } ring_ctl_t;

  // ring status back to the decode side
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       empty_nxt;
    logic [6:0] head_char;
  } ring_sts_t;

  function automatic logic is_nav_key(input logic [7:0] sc);
    logic r;
    r = (sc == SC_HOME) || (sc == SC_UP) || (sc == SC_PGUP) ||
        (sc == SC_END) || (sc == SC_DOWN) || (sc == SC_PGDN);
    return r;
  endfunction

  // set-1 make code to ascii, zero where unmapped
  function automatic logic [6:0] map_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// File: design/scfifo_ring.sv
// character ring: storage memory, read/write pointers and head prefetch
// depends on scfifo_pkg
`timescale 1ns / 1ps

module scfifo_ring #(
  parameter int RING_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scfifo_pkg::ring_ctl_t ctl,
  output scfifo_pkg::ring_sts_t sts
);

  localparam int              PTR_W    = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [6:0]       mem [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic [6:0]       head_r;
  logic             empty, full, do_push, do_pop;

  // wrapping increments
  assign wr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign empty   = (rd_ptr_r == wr_ptr_r);
  assign full    = (wr_inc == rd_ptr_r);
  assign do_push = ctl.push && !full;
  assign do_pop  = ctl.pop && !empty;

  assign wr_ptr_nxt = do_push ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_inc : rd_ptr_r;

  // pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // storage write and head prefetch, forwarding a write to the next head slot
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= ctl.push_char;
    end
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctl.push_char;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.empty_nxt = (rd_ptr_nxt == wr_ptr_nxt);
  assign sts.head_char = head_r;

endmodule

// File: design/scfifo_scroll.sv
// scroll row register and navigation key handling
// depends on scfifo_pkg
`timescale 1ns / 1ps

module scfifo_scroll (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        key_en,
  input  logic [7:0]  scancode,
  input  logic [11:0] cursor_row,
  input  logic [7:0]  page_lines,
  output logic [11:0] row_nxt,
  output logic        redraw
);

  localparam logic [11:0] ROWS     = 12'(scfifo_pkg::SCREEN_ROWS);
  localparam logic [11:0] ROWS_M1  = 12'(scfifo_pkg::SCREEN_ROWS - 1);

  logic [11:0] row_r;
  logic [11:0] row_new;
  logic        redraw_new;
  logic [12:0] pgdn_sum;
  logic [11:0] pl_ext;

  assign pl_ext   = {4'b0, page_lines};
  assign pgdn_sum = {1'b0, row_r} + {5'b0, page_lines};

  // per-key row update
  always_comb begin
    row_new    = row_r;
    redraw_new = 1'b0;
    case (scancode)
      scfifo_pkg::SC_UP: begin
        if (row_r != '0) begin
          row_new    = row_r - 1'b1;
          redraw_new = 1'b1;
        end
      end
      scfifo_pkg::SC_DOWN: begin
        if (row_r < cursor_row) begin
          row_new    = row_r + 1'b1;
          redraw_new = 1'b1;
        end
      end
      scfifo_pkg::SC_PGUP: begin
        row_new    = (row_r > pl_ext) ? row_r - pl_ext : '0;
        redraw_new = 1'b1;
      end
      scfifo_pkg::SC_PGDN: begin
        row_new    = (pgdn_sum > {1'b0, cursor_row}) ? cursor_row : pgdn_sum[11:0];
        redraw_new = 1'b1;
      end
      scfifo_pkg::SC_HOME: begin
        row_new    = '0;
        redraw_new = 1'b1;
      end
      scfifo_pkg::SC_END: begin
        row_new    = (cursor_row >= ROWS) ? cursor_row - ROWS_M1 : '0;
        redraw_new = 1'b1;
      end
      default: begin
        row_new    = row_r;
        redraw_new = 1'b0;
      end
    endcase
  end

  assign row_nxt = key_en ? row_new : row_r;
  assign redraw  = key_en && redraw_new;

  // scroll row register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

endmodule

// File: design/scancode_to_char_fifo_unit.sv
// The output register takes the result word of an accepted input word in the next cycle.
// Throughput: one word per cycle when the output is not stalled; the ring head is prefetched
// from the memory every cycle, with a write to the next head slot forwarded, so reads and
// pushes may alternate freely. Input stalls only while a result waits on a stalled output.
// Reset (synchronous, rst_n low) clears pointers, scroll row and output valid, and sets
// page_lines to 20; ring contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
`include "scancode_to_char_fifo_unit_macros.svh"

module scancode_to_char_fifo_unit #(
  parameter int RING_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_scancode,
  input  logic [11:0] in_cursor_row,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_char_valid,
  output logic [6:0]  out_char_out,
  output logic        out_fifo_empty,
  output logic        out_dropped,
  output logic [11:0] out_scroll_row,
  output logic        out_redraw
);

  logic                  page_step_set;
  logic [7:0]            page_lines_r;
  logic                  accept;
  logic                  key_word;
  logic                  nav_key;
  logic [6:0]            mapped;
  logic                  push_req;
  logic                  pop_ok;
  logic [11:0]           row_nxt;
  logic                  redraw;
  scfifo_pkg::ring_ctl_t ring_ctl;
  scfifo_pkg::ring_sts_t ring_sts;

  logic                  out_valid_r;
  logic                  char_valid_r;
  logic [6:0]            char_out_r;
  logic                  fifo_empty_r;
  logic                  dropped_r;
  logic [11:0]           scroll_row_r;
  logic                  redraw_r;

  // page step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_lines_r <= scfifo_pkg::PAGE_LINES_RST;
    end else if (cfg_we) begin
      page_lines_r <= cfg_wdata;
    end
  end
  assign page_step_set = |page_lines_r;

  // handshake
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // decode
  assign key_word = (in_kind == scfifo_pkg::KIND_SCAN) && !in_scancode[7];
  assign nav_key  = scfifo_pkg::is_nav_key(in_scancode);
  assign mapped   = scfifo_pkg::map_char(in_scancode[6:0]);
  assign push_req = accept && key_word && !nav_key && (mapped != '0);
  assign pop_ok   = accept && (in_kind == scfifo_pkg::KIND_READ) && !ring_sts.empty;

  assign ring_ctl.push      = push_req;
  assign ring_ctl.pop       = pop_ok;
  assign ring_ctl.push_char = mapped;

  scfifo_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .sts   (ring_sts)
  );

  scfifo_scroll u_scroll (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_en     (accept && key_word),
    .scancode   (in_scancode),
    .cursor_row (in_cursor_row),
    .page_lines (page_lines_r),
    .row_nxt    (row_nxt),
    .redraw     (redraw)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      char_valid_r <= pop_ok;
      char_out_r   <= pop_ok ? ring_sts.head_char : '0;
      fifo_empty_r <= ring_sts.empty_nxt;
      dropped_r    <= push_req && ring_sts.full;
      scroll_row_r <= row_nxt;
      redraw_r     <= redraw;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = char_valid_r;
  assign out_char_out   = char_out_r;
  assign out_fifo_empty = fifo_empty_r;
  assign out_dropped    = dropped_r;
  assign out_scroll_row = scroll_row_r;
  assign out_redraw     = redraw_r;

  // checks
  `SCF_ASSERT_IMP(a_ring_not_full_and_empty, clk, rst_n, ring_sts.full, !ring_sts.empty)
  `SCF_ASSERT_NXT(a_push_fills_ring, clk, rst_n, push_req && !ring_sts.full, !ring_sts.empty)
  `SCF_ASSERT_IMP(a_result_kinds_exclusive, clk, rst_n, out_valid_r && char_valid_r, !dropped_r && !redraw_r)
  `SCF_ASSERT_IMP(a_page_step_nonzero_after_reset, clk, rst_n, $past(!rst_n), page_step_set)

endmodule
